// ===== hdl/jcqt_pkg.sv =====
package jcqt_pkg;

   // default table depth
   localparam int MAX_MEMBERS_DEF = 16;

   // count width that covers tables of up to 127 entries
   localparam int CNT_W = 7;

   localparam int KIND_W = 3;
   localparam int ID_W   = 64;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FINALIZE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_VOTE     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_QUORUM   = 3'd6;

   // token that walks the row of cells, once to search and once to update
   typedef struct packed {
      logic              valid;
      logic              pass_upd;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic              joint;
      logic              hit;
      logic              free_seen;
      logic              member;
      logic              go;
      logic [CNT_W-1:0]  sz_cur;
      logic [CNT_W-1:0]  vt_cur;
      logic [CNT_W-1:0]  sz_old;
      logic [CNT_W-1:0]  vt_old;
      logic [CNT_W-1:0]  sz_new;
      logic [CNT_W-1:0]  vt_new;
   } token_type;

endpackage

// ===== hdl/jcqt_cell.sv =====
module jcqt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  jcqt_pkg::token_type   tok_in,
   output jcqt_pkg::token_type   tok_out
);

   logic [jcqt_pkg::ID_W-1:0] id_ff, id_in;
   logic used_ff, used_in;
   logic cur_ff, cur_in;
   logic old_ff, old_in;
   logic new_ff, new_in;
   logic voted_ff, voted_in;
   jcqt_pkg::token_type tok_ff, tok_nxt_in;

   logic match;
   logic claim;
   logic upd;

   always_comb begin
      match = used_ff && (id_ff == tok_in.id);
      // lowest free entry: used entries always form a prefix of the row
      claim = !used_ff && !tok_in.free_seen && !tok_in.hit;
      upd   = tok_in.valid && tok_in.pass_upd && tok_in.go;

      id_in    = id_ff;
      used_in  = used_ff;
      cur_in   = cur_ff;
      old_in   = old_ff;
      new_in   = new_ff;
      voted_in = voted_ff;

      // carry flags and tallies to the next cell
      tok_nxt_in           = tok_in;
      tok_nxt_in.hit       = tok_in.hit | match;
      tok_nxt_in.free_seen = tok_in.free_seen | !used_ff;
      if (!tok_in.pass_upd) begin
         tok_nxt_in.member = tok_in.member |
            (match & (tok_in.joint ? (old_ff | new_ff) : cur_ff));
         tok_nxt_in.sz_cur = tok_in.sz_cur + jcqt_pkg::CNT_W'(used_ff & cur_ff);
         tok_nxt_in.vt_cur = tok_in.vt_cur + jcqt_pkg::CNT_W'(used_ff & cur_ff & voted_ff);
         tok_nxt_in.sz_old = tok_in.sz_old + jcqt_pkg::CNT_W'(used_ff & old_ff);
         tok_nxt_in.vt_old = tok_in.vt_old + jcqt_pkg::CNT_W'(used_ff & old_ff & voted_ff);
         tok_nxt_in.sz_new = tok_in.sz_new + jcqt_pkg::CNT_W'(used_ff & new_ff);
         tok_nxt_in.vt_new = tok_in.vt_new + jcqt_pkg::CNT_W'(used_ff & new_ff & voted_ff);
      end

      // apply the item to this entry on the update walk
      if (upd) begin
         case (tok_in.kind)
            jcqt_pkg::KIND_LOAD: begin
               if (match) begin
                  cur_in = 1'b1;
               end else if (claim) begin
                  used_in = 1'b1;
                  id_in   = tok_in.id;
                  cur_in  = 1'b1;
               end
            end
            jcqt_pkg::KIND_ADD: begin
               old_in = cur_ff;
               new_in = cur_ff | match | claim;
               if (claim) begin
                  used_in = 1'b1;
                  id_in   = tok_in.id;
               end
            end
            jcqt_pkg::KIND_REMOVE: begin
               old_in = cur_ff;
               new_in = cur_ff & !match;
            end
            jcqt_pkg::KIND_FINALIZE: begin
               cur_in = new_ff;
               old_in = 1'b0;
               new_in = 1'b0;
            end
            jcqt_pkg::KIND_VOTE: begin
               if (match) begin
                  voted_in = 1'b1;
               end
            end
            jcqt_pkg::KIND_QUORUM: begin
               voted_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // entry state
   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) begin
         used_ff  <= 1'b0;
         cur_ff   <= 1'b0;
         old_ff   <= 1'b0;
         new_ff   <= 1'b0;
         voted_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         cur_ff   <= cur_in;
         old_ff   <= old_in;
         new_ff   <= new_in;
         voted_ff <= voted_in;
      end
   end

   // token stage toward the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_nxt_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== hdl/jcqt_ctrl.sv =====
module jcqt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jcqt_pkg::KIND_W-1:0]   req_kind,
   input  logic [jcqt_pkg::ID_W-1:0]     req_node_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_member,
   output logic                          rsp_has_quorum,
   output logic                          rsp_status,
   output jcqt_pkg::token_type           launch,
   input  jcqt_pkg::token_type           tail
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic joint_ff, joint_in;
   jcqt_pkg::token_type launch_ff, launch_in;
   logic [jcqt_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [jcqt_pkg::ID_W-1:0] id_ff, id_in;
   logic pm_ff, pm_in, pq_ff, pq_in, ps_ff, ps_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rm_ff, rm_in, rq_ff, rq_in, rs_ff, rs_in;

   logic full;
   logic q_cur, q_old, q_new;
   logic deliver;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      full  = !tail.hit && !tail.free_seen;
      q_cur = tail.vt_cur > (tail.sz_cur >> 1);
      q_old = tail.vt_old > (tail.sz_old >> 1);
      q_new = tail.vt_new > (tail.sz_new >> 1);

      state_in     = state_ff;
      joint_in     = joint_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      pm_in        = pm_ff;
      pq_in        = pq_ff;
      ps_in        = ps_ff;
      rm_in        = rm_ff;
      rq_in        = rq_ff;
      rs_in        = rs_ff;
      launch_in    = '0;
      deliver      = 1'b0;
      rsp_valid_in = rsp_valid_ff & !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            // start the search walk
            if (req_valid) begin
               kind_in         = req_kind;
               id_in           = req_node_id;
               launch_in.valid = 1'b1;
               launch_in.kind  = req_kind;
               launch_in.id    = req_node_id;
               launch_in.joint = joint_ff;
               state_in        = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (tail.valid && !tail.pass_upd) begin
               // search done: settle the answer and start the update walk
               pm_in = (kind_ff == jcqt_pkg::KIND_QUERY) & tail.member;
               pq_in = (kind_ff == jcqt_pkg::KIND_QUORUM) &
                       (joint_ff ? (q_old & q_new) : q_cur);
               ps_in = (kind_ff inside {jcqt_pkg::KIND_LOAD, jcqt_pkg::KIND_ADD}) & full;
               launch_in.valid    = 1'b1;
               launch_in.pass_upd = 1'b1;
               launch_in.kind     = kind_ff;
               launch_in.id       = id_ff;
               launch_in.joint    = joint_ff;
               launch_in.hit      = tail.hit;
               case (kind_ff)
                  jcqt_pkg::KIND_ADD:      launch_in.go = !full;
                  jcqt_pkg::KIND_FINALIZE: launch_in.go = joint_ff;
                  default:                 launch_in.go = 1'b1;
               endcase
            end else if (tail.valid && tail.pass_upd) begin
               // update done: change mode, then hand over the result
               case (kind_ff)
                  jcqt_pkg::KIND_ADD:      joint_in = joint_ff | tail.go;
                  jcqt_pkg::KIND_REMOVE:   joint_in = 1'b1;
                  jcqt_pkg::KIND_FINALIZE: joint_in = 1'b0;
                  default:                 joint_in = joint_ff;
               endcase
               if (!rsp_valid_ff || rsp_ready) begin
                  deliver  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               deliver  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register
      if (deliver) begin
         rsp_valid_in = 1'b1;
         rm_in        = pm_ff;
         rq_in        = pq_ff;
         rs_in        = ps_ff;
      end
      if (state_ff == ST_BUSY && tail.valid && !tail.pass_upd) begin
         rm_in = rm_ff;
      end
   end

   // sequencer, item and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         joint_ff     <= 1'b0;
         launch_ff    <= '0;
         kind_ff      <= '0;
         id_ff        <= '0;
         pm_ff        <= 1'b0;
         pq_ff        <= 1'b0;
         ps_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rm_ff        <= 1'b0;
         rq_ff        <= 1'b0;
         rs_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         joint_ff     <= joint_in;
         launch_ff    <= launch_in;
         kind_ff      <= kind_in;
         id_ff        <= id_in;
         pm_ff        <= pm_in;
         pq_ff        <= pq_in;
         ps_ff        <= ps_in;
         rsp_valid_ff <= rsp_valid_in;
         rm_ff        <= rm_in;
         rq_ff        <= rq_in;
         rs_ff        <= rs_in;
      end
   end

   assign launch         = launch_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_member  = rm_ff;
   assign rsp_has_quorum = rq_ff;
   assign rsp_status     = rs_ff;

endmodule

// ===== hdl/joint_consensus_quorum_table.sv =====
// Joint-consensus membership table with quorum check.
//
// Input channel req_* (valid/ready): one beat is one item, req_kind selects
// load member, joint add, joint remove, finalize, query, vote or quorum
// check, req_node_id names the node. Result channel rsp_* (valid/ready):
// exactly one beat per item, in order, carrying is_member, has_quorum and
// status (table full, insert refused).
//
// The table is a row of MAX_MEMBERS cells, one entry each. An item walks the
// row twice as a token moving one cell per cycle: a search walk that finds
// the id, the lowest free entry and the set tallies, then an update walk
// that applies the change. A new item is accepted only after the update walk
// of the previous item is done.
//
// A finished result waits in the output register while the next item is
// accepted and searched; if the receiver still stalls when that item is done,
// the block holds it until the output register frees. Synchronous reset
// empties the table, clears all marks and the joint flag, and drops any beat
// in flight; the block is ready in the first cycle after reset.
module joint_consensus_quorum_table #(
   parameter int MAX_MEMBERS = jcqt_pkg::MAX_MEMBERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jcqt_pkg::KIND_W-1:0]   req_kind,
   input  logic [jcqt_pkg::ID_W-1:0]     req_node_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_member,
   output logic                          rsp_has_quorum,
   output logic                          rsp_status
);

   jcqt_pkg::token_type tok [MAX_MEMBERS+1];

   // sequencer and result register
   jcqt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_node_id    (req_node_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_member  (rsp_is_member),
      .rsp_has_quorum (rsp_has_quorum),
      .rsp_status     (rsp_status),
      .launch         (tok[0]),
      .tail           (tok[MAX_MEMBERS])
   );

   // row of table entries
   for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
      jcqt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

endmodule
